// File: hw/rtl/ufr_pkg.sv
`default_nettype none
package ufr_pkg;

    // Default frame size limits
    localparam int MAX_PAYLOAD_DEF   = 64;
    localparam int SHORT_PAYLOAD_DEF = 2;

    // Register file
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_PROTOCOL_MODE = 2'd0;
    localparam logic [1:0] REG_HEAD_FIRST    = 2'd1;
    localparam logic [1:0] REG_HEAD_SECOND   = 2'd2;
    localparam logic [1:0] REG_VERSION_VALUE = 2'd3;

    localparam logic       PROTOCOL_MODE_RST = 1'b1;
    localparam logic [7:0] HEAD_FIRST_RST    = 8'h55;
    localparam logic [7:0] HEAD_SECOND_RST   = 8'hAA;
    localparam logic [7:0] VERSION_VALUE_RST = 8'h00;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic       protocol_mode;
        logic [7:0] head_first;
        logic [7:0] head_second;
        logic [7:0] version_value;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic [7:0] command;
        logic [6:0] payload_length;
        logic       checksum_ok;
    } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/ufr_regs.sv
`default_nettype none
module ufr_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ufr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ufr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [ufr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output ufr_pkg::cfg_t                         cfg
);

    ufr_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.protocol_mode <= ufr_pkg::PROTOCOL_MODE_RST;
            cfg_reg.head_first    <= ufr_pkg::HEAD_FIRST_RST;
            cfg_reg.head_second   <= ufr_pkg::HEAD_SECOND_RST;
            cfg_reg.version_value <= ufr_pkg::VERSION_VALUE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                ufr_pkg::REG_PROTOCOL_MODE: cfg_reg.protocol_mode <= pwdata[0];
                ufr_pkg::REG_HEAD_FIRST:    cfg_reg.head_first    <= pwdata[7:0];
                ufr_pkg::REG_HEAD_SECOND:   cfg_reg.head_second   <= pwdata[7:0];
                ufr_pkg::REG_VERSION_VALUE: cfg_reg.version_value <= pwdata[7:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            ufr_pkg::REG_PROTOCOL_MODE: prdata[0]   = cfg_reg.protocol_mode;
            ufr_pkg::REG_HEAD_FIRST:    prdata[7:0] = cfg_reg.head_first;
            ufr_pkg::REG_HEAD_SECOND:   prdata[7:0] = cfg_reg.head_second;
            ufr_pkg::REG_VERSION_VALUE: prdata[7:0] = cfg_reg.version_value;
            default:                    prdata      = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/ufr_parser.sv
`default_nettype none
module ufr_parser #(
    parameter int MAX_PAYLOAD   = ufr_pkg::MAX_PAYLOAD_DEF,
    parameter int SHORT_PAYLOAD = ufr_pkg::SHORT_PAYLOAD_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ufr_pkg::cfg_t cfg,
    input  wire logic          step,       // byte in rx_byte is consumed this cycle
    input  wire logic [7:0]    rx_byte,
    input  wire logic          res_stall,
    output logic               res_valid,
    output ufr_pkg::res_t      res
);

    localparam int MAX_LEN = (MAX_PAYLOAD > SHORT_PAYLOAD) ? MAX_PAYLOAD : SHORT_PAYLOAD;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEAD0  = 3'd1;
    localparam logic [2:0] PH_HEAD1  = 3'd2;
    localparam logic [2:0] PH_VER    = 3'd3;
    localparam logic [2:0] PH_CMD    = 3'd4;
    localparam logic [2:0] PH_LENHI  = 3'd5;
    localparam logic [2:0] PH_BUSY   = 3'd6;
    localparam logic [2:0] PH_VERIFY = 3'd7;

    logic [2:0]       phase_reg,   phase_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] exp_len_reg, exp_len_next;
    logic [7:0]       len_hi_reg,  len_hi_next;
    logic [7:0]       cmd_reg,     cmd_next;
    logic [7:0]       sum_reg,     sum_next;
    logic             res_valid_reg, res_valid_next;
    ufr_pkg::res_t    res_reg,     res_next;

    logic             emit;
    logic [7:0]       sum_add;
    logic [15:0]      len16;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      count_ext;
    logic [15:0]      exp_ext;

    assign sum_add   = sum_reg + rx_byte;
    assign len16     = {len_hi_reg, rx_byte};
    assign count_inc = count_reg + CNT_W'(1);
    assign count_ext = 16'(count_reg);
    assign exp_ext   = 16'(exp_len_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        exp_len_next = exp_len_reg;
        len_hi_next  = len_hi_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        emit         = 1'b0;
        res_next     = res_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == cfg.head_first)
                begin
                    sum_next   = rx_byte;
                    count_next = '0;
                    phase_next = PH_HEAD0;
                end
            end
            PH_HEAD0:
            begin
                if (rx_byte == cfg.head_second)
                begin
                    sum_next   = sum_add;
                    phase_next = PH_HEAD1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            PH_HEAD1:
            begin
                if (cfg.protocol_mode)
                begin
                    if (rx_byte == cfg.version_value)
                    begin
                        sum_next   = sum_add;
                        phase_next = PH_VER;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                else
                begin
                    // short mode: this byte is the command
                    sum_next     = sum_add;
                    cmd_next     = rx_byte;
                    exp_len_next = CNT_W'(SHORT_PAYLOAD);
                    count_next   = '0;
                    phase_next   = PH_BUSY;
                end
            end
            PH_VER:
            begin
                sum_next   = sum_add;
                cmd_next   = rx_byte;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                sum_next    = sum_add;
                len_hi_next = rx_byte;
                phase_next  = PH_LENHI;
            end
            PH_LENHI:
            begin
                sum_next   = sum_add;
                count_next = '0;
                if (len16 > 16'(MAX_PAYLOAD))
                begin
                    // oversize frame dropped silently
                    phase_next = PH_IDLE;
                end
                else
                begin
                    exp_len_next = len16[CNT_W-1:0];
                    phase_next   = (len16 != 16'd0) ? PH_BUSY : PH_VERIFY;
                end
            end
            PH_BUSY:
            begin
                sum_next                = sum_add;
                emit                    = 1'b1;
                res_next.kind           = ufr_pkg::KIND_PAYLOAD;
                res_next.data_byte      = rx_byte;
                res_next.byte_index     = count_ext[5:0];
                res_next.command        = cmd_reg;
                res_next.payload_length = exp_ext[6:0];
                res_next.checksum_ok    = 1'b0;
                count_next              = count_inc;
                if (count_inc >= exp_len_reg)
                begin
                    phase_next = PH_VERIFY;
                end
            end
            PH_VERIFY:
            begin
                emit                    = 1'b1;
                res_next.kind           = ufr_pkg::KIND_END;
                res_next.data_byte      = 8'd0;
                res_next.byte_index     = 6'd0;
                res_next.command        = cmd_reg;
                res_next.payload_length = count_ext[6:0];
                res_next.checksum_ok    = (sum_reg == rx_byte);
                phase_next              = PH_IDLE;
                count_next              = '0;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // result register: new beat on emit, otherwise drop once taken
    assign res_valid_next = (step && emit) ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            exp_len_reg   <= '0;
            len_hi_reg    <= 8'd0;
            cmd_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (step)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                exp_len_reg <= exp_len_next;
                len_hi_reg  <= len_hi_next;
                cmd_reg     <= cmd_next;
                sum_reg     <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// File: hw/rtl/uart_frame_receiver.sv
`default_nettype none
// UART frame receiver: parses header / length / checksum frames from a byte stream.
//
// Input channel: rx_valid, rx_stall, rx_byte. One received byte per beat.
// Output channel: result_valid, result_stall, and the result fields. A beat is
// either a payload byte (kind 0) or an end-of-frame summary (kind 1) carrying
// command, payload length and the checksum pass flag. Header bytes, version,
// command and length bytes produce no beat.
// Config: APB registers protocol_mode, head_first, head_second, version_value
// at byte addresses 0x0, 0x4, 0x8, 0xC. pready is tied high.
//
// Data path: a byte is parsed while it sits in the input register, and its result
// lands in the result register at the edge that ends that parse step.
// Throughput: one byte per cycle while no result waits; the parse step updates
// state, running sum and counters all together.
// Stall: a waiting result holds the parse step; the input register still takes
// one more byte if it is empty, then rx_stall rises until the result is taken.
// Reset (rst_n low, async): parser back to hunting for head_first, all
// pipeline stages empty, registers at their reset values.
module uart_frame_receiver #(
    parameter int MAX_PAYLOAD   = ufr_pkg::MAX_PAYLOAD_DEF,
    parameter int SHORT_PAYLOAD = ufr_pkg::SHORT_PAYLOAD_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB config
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ufr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [ufr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [ufr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // byte input
    input  wire logic                            rx_valid,
    output logic                                 rx_stall,
    input  wire logic [7:0]                      rx_byte,
    // results
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic                                 kind,
    output logic      [7:0]                      data_byte,
    output logic      [5:0]                      byte_index,
    output logic      [7:0]                      command,
    output logic      [6:0]                      payload_length,
    output logic                                 checksum_ok
);

    ufr_pkg::cfg_t cfg;
    ufr_pkg::res_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step;       // parse the held byte this cycle
    logic       rx_take;

    ufr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parse only when the result register can take a beat
    assign step     = in_valid_reg && (!result_valid || !result_stall);
    assign rx_stall = in_valid_reg && !step;
    assign rx_take  = rx_valid && !rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    ufr_parser #(
        .MAX_PAYLOAD   (MAX_PAYLOAD),
        .SHORT_PAYLOAD (SHORT_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .res_stall (result_stall),
        .res_valid (result_valid),
        .res       (res)
    );

    assign kind           = res.kind;
    assign data_byte      = res.data_byte;
    assign byte_index     = res.byte_index;
    assign command        = res.command;
    assign payload_length = res.payload_length;
    assign checksum_ok    = res.checksum_ok;

endmodule
`default_nettype wire

// File: tb/sv/uart_frame_receiver_tb.sv
`timescale 1ns / 1ps

// Frame receiver bench: short directed table, then random frame traffic under
// six register settings and three idle/stall mixes. Every result beat is
// checked field by field against the directed table or a bench-side parser.
module uart_frame_receiver_tb;
    import ufr_pkg::*;

    // The pipeline is the input register and the result register; the settle wait
    // also covers a byte still in flight that makes no beat.
    localparam int SETTLE_CYCLES     = 6;
    localparam int TIMEOUT_NS        = 2_000_000;
    localparam int BYTES_PER_SETTING = 220;
    localparam int NUM_SETTINGS      = 6;

    // Parser position within a frame
    typedef enum logic [2:0] {
        HUNT,
        GOT_HEAD0,
        GOT_HEAD1,
        GOT_VERSION,
        GOT_COMMAND,
        GOT_LEN_HIGH,
        IN_PAYLOAD,
        AT_CHECKSUM
    } hunt_state_t;

    // Directed table row: a byte beat or a register write
    typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t    op;
        logic [1:0] reg_sel;
        logic [7:0] val;
        bit         typed;   // want holds the beat this byte must give
        res_t       want;
    } dir_row_t;

    localparam res_t NO_RES = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  rx_valid;
    logic                  rx_stall;
    logic [7:0]            rx_byte;
    logic                  result_valid;
    logic                  result_stall;
    logic                  kind;
    logic [7:0]            data_byte;
    logic [5:0]            byte_index;
    logic [7:0]            command;
    logic [6:0]            payload_length;
    logic                  checksum_ok;

    uart_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .command        (command),
        .payload_length (payload_length),
        .checksum_ok    (checksum_ok)
    );

    // Bench copy of the registers and the parser state
    cfg_t        cfg_mirror = '{PROTOCOL_MODE_RST, HEAD_FIRST_RST,
                                HEAD_SECOND_RST, VERSION_VALUE_RST};
    hunt_state_t hunt_st    = HUNT;
    int          pay_cnt    = 0;
    logic [15:0] frame_len  = '0;
    logic [7:0]  len_hi     = '0;
    logic [7:0]  frame_cmd  = '0;
    logic [7:0]  sum_so_far = '0;

    res_t       due_beats[$];   // beats predicted, not yet seen
    logic [7:0] tx_seq[$];      // bytes of the sequence being sent
    dir_row_t   dir_rows[$];
    res_t       oldest;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int bytes_sent    = 0;
    int payload_seen  = 0;
    int ends_seen     = 0;
    int good_sums     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // Receiver side: random stall, changed on the falling edge
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Parses one accepted byte, advances the bench state, returns 1 with the
    // beat in r when the byte gives one.
    function automatic bit parse_rx_byte(input logic [7:0] b, output res_t r);
        bit got;
        got = 1'b0;
        r   = '0;
        case (hunt_st)
            HUNT:
            begin
                if (b == cfg_mirror.head_first)
                begin
                    sum_so_far = b;
                    pay_cnt    = 0;
                    hunt_st    = GOT_HEAD0;
                end
            end
            GOT_HEAD0:
            begin
                // a wrong second header is dropped, not retried as a first
                if (b == cfg_mirror.head_second)
                begin
                    sum_so_far += b;
                    hunt_st     = GOT_HEAD1;
                end
                else
                begin
                    hunt_st = HUNT;
                    pay_cnt = 0;
                end
            end
            GOT_HEAD1:
            begin
                // mode is looked at here only; later bytes keep this choice
                if (cfg_mirror.protocol_mode)
                begin
                    if (b == cfg_mirror.version_value)
                    begin
                        sum_so_far += b;
                        hunt_st     = GOT_VERSION;
                    end
                    else
                    begin
                        hunt_st = HUNT;
                        pay_cnt = 0;
                    end
                end
                else
                begin
                    sum_so_far += b;
                    frame_cmd   = b;
                    frame_len   = 16'(SHORT_PAYLOAD_DEF);
                    pay_cnt     = 0;
                    hunt_st     = IN_PAYLOAD;
                end
            end
            GOT_VERSION:
            begin
                sum_so_far += b;
                frame_cmd   = b;
                hunt_st     = GOT_COMMAND;
            end
            GOT_COMMAND:
            begin
                sum_so_far += b;
                len_hi      = b;
                hunt_st     = GOT_LEN_HIGH;
            end
            GOT_LEN_HIGH:
            begin
                sum_so_far += b;
                frame_len   = {len_hi, b};
                pay_cnt     = 0;
                if (frame_len > MAX_PAYLOAD_DEF)
                begin
                    // oversize: silently back to hunting
                    frame_len = '0;
                    hunt_st   = HUNT;
                end
                else if (frame_len != 0)
                    hunt_st = IN_PAYLOAD;
                else
                    hunt_st = AT_CHECKSUM;
            end
            IN_PAYLOAD:
            begin
                sum_so_far      += b;
                r.kind           = KIND_PAYLOAD;
                r.data_byte      = b;
                r.byte_index     = pay_cnt[5:0];
                r.command        = frame_cmd;
                r.payload_length = frame_len[6:0];
                r.checksum_ok    = 1'b0;
                got              = 1'b1;
                pay_cnt++;
                if (pay_cnt >= frame_len)
                    hunt_st = AT_CHECKSUM;
            end
            default:
            begin
                // checksum byte closes the frame, pass or not
                r.kind           = KIND_END;
                r.command        = frame_cmd;
                r.payload_length = pay_cnt[6:0];
                r.checksum_ok    = (sum_so_far == b);
                got              = 1'b1;
                hunt_st          = HUNT;
                pay_cnt          = 0;
            end
        endcase
        return got;
    endfunction

    // Offers one byte beat; entered and left on a falling edge with rx_valid
    // still high, so back-to-back beats keep valid up.
    task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
        res_t r;
        bit   got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall !== 1'b0)
            @(posedge clk);
        got = parse_rx_byte(b, r);
        if (typed)
            due_beats.push_back(typed_res);
        else if (got)
            due_beats.push_back(r);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Sender holds off until every predicted beat is out and the pipe is empty
    task automatic wait_drain();
        rx_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; mirror follows on completion
    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROTOCOL_MODE: cfg_mirror.protocol_mode = value[0];
            REG_HEAD_FIRST:    cfg_mirror.head_first    = value;
            REG_HEAD_SECOND:   cfg_mirror.head_second   = value;
            default:           cfg_mirror.version_value = value;
        endcase
    endtask

    // Mostly short payloads, now and then the full 63/64
    function automatic int unsigned pick_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return $urandom_range(0, 6);
        else if (p < 75)
            return $urandom_range(7, 20);
        else if (p < 88)
            return $urandom_range(21, 62);
        return $urandom_range(MAX_PAYLOAD_DEF - 1, MAX_PAYLOAD_DEF);
    endfunction

    // Appends one frame under the current headers. An oversize long-mode
    // length stops after the length bytes, since the parser drops it there.
    function automatic void add_frame(input bit long_mode, input int unsigned len,
                                      input bit good_sum);
        logic [7:0]  sum;
        int          first;
        int unsigned n;
        first = tx_seq.size();
        n     = len;
        tx_seq.push_back(cfg_mirror.head_first);
        tx_seq.push_back(cfg_mirror.head_second);
        if (long_mode)
        begin
            tx_seq.push_back(cfg_mirror.version_value);
            tx_seq.push_back(8'($urandom));
            tx_seq.push_back(8'(n >> 8));
            tx_seq.push_back(8'(n));
            if (n > MAX_PAYLOAD_DEF)
                return;
        end
        else
        begin
            tx_seq.push_back(8'($urandom));
            n = SHORT_PAYLOAD_DEF;
        end
        repeat (n)
            tx_seq.push_back(8'($urandom));
        sum = '0;
        for (int i = first; i < tx_seq.size(); i++)
            sum += tx_seq[i];
        tx_seq.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endfunction

    // Random traffic for one setting: mostly well-formed frames with random
    // content, plus cut-off frames, bad headers, oversize lengths and noise.
    task automatic run_setting(input int target);
        int counted;
        int pick;
        int cut;
        int pos;
        counted = 0;
        while (counted < target)
        begin
            tx_seq.delete();
            pick = $urandom_range(0, 99);
            if (pick < 68)
                add_frame(cfg_mirror.protocol_mode, pick_len(), $urandom_range(0, 3) != 0);
            else if (pick < 78)
            begin
                // cut short, either mode: the next frame's bytes land in this one
                add_frame($urandom_range(0, 1), pick_len(), 1'b1);
                cut = $urandom_range(1, tx_seq.size() - 1);
                repeat (cut)
                    void'(tx_seq.pop_back());
            end
            else if (pick < 86)
            begin
                // wrong second header, or wrong version in long mode
                add_frame(cfg_mirror.protocol_mode, pick_len(), 1'b1);
                pos = $urandom_range(1, cfg_mirror.protocol_mode ? 2 : 1);
                tx_seq[pos] ^= 8'($urandom_range(1, 255));
            end
            else if (pick < 93)
                add_frame(1'b1, $urandom_range(0, 1) ? $urandom_range(65, 255)
                                                     : $urandom_range(256, 65535), 1'b1);
            else
            begin
                repeat ($urandom_range(1, 6))
                    tx_seq.push_back(8'($urandom));
            end
            if (pick < 93)
                counted += tx_seq.size();
            foreach (tx_seq[i])
                send_byte(tx_seq[i], 1'b0, NO_RES);
        end
    endtask

    task automatic check_field(input string fname, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            mismatches++;
        end
    endtask

    // Result monitor: each taken beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (due_beats.size() == 0)
            begin
                $error("unexpected result beat: kind %0d data %0d cmd %0d",
                       kind, data_byte, command);
                mismatches++;
            end
            else
            begin
                oldest = due_beats.pop_front();
                check_field("kind", 8'(oldest.kind), 8'(kind));
                check_field("data_byte", oldest.data_byte, data_byte);
                check_field("byte_index", 8'(oldest.byte_index), 8'(byte_index));
                check_field("command", oldest.command, command);
                check_field("payload_length", 8'(oldest.payload_length),
                            8'(payload_length));
                check_field("checksum_ok", 8'(oldest.checksum_ok), 8'(checksum_ok));
                if (oldest.kind == KIND_END)
                begin
                    ends_seen++;
                    if (oldest.checksum_ok)
                        good_sums++;
                end
                else
                    payload_seen++;
            end
        end
    end

    initial
    begin
        cfg_t next_cfg;
        int   setting;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rx_valid = 1'b0;
        rx_byte  = '0;

        // Directed frames under reset registers (long mode, 55/AA, version 00)
        dir_rows = '{
            // long frame, one payload byte, good checksum
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hC3, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h01, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h7E, 1'b1,
              '{KIND_PAYLOAD, 8'h7E, 6'd0, 8'hC3, 7'd1, 1'b0}},
            '{ROW_BYTE, 2'd0, 8'h41, 1'b1,
              '{KIND_END, 8'h00, 6'd0, 8'hC3, 7'd1, 1'b1}},
            // zero length goes straight to the checksum
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hFE, 1'b1,
              '{KIND_END, 8'h00, 6'd0, 8'hFF, 7'd0, 1'b1}},
            // length 256 is over the limit: dropped, no beat
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h01, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h01, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            // wrong second header; it is not taken as a new first header
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, NO_RES},
            // headers in long mode, switch to short before the next byte,
            // then a short frame with a bad checksum
            '{ROW_BYTE, 2'd0, 8'h55, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hAA, 1'b0, NO_RES},
            '{ROW_CFG, REG_PROTOCOL_MODE, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 2'd0, 8'hFF, 1'b1,
              '{KIND_PAYLOAD, 8'hFF, 6'd0, 8'h00, 7'd2, 1'b0}},
            '{ROW_BYTE, 2'd0, 8'h80, 1'b1,
              '{KIND_PAYLOAD, 8'h80, 6'd1, 8'h00, 7'd2, 1'b0}},
            '{ROW_BYTE, 2'd0, 8'h00, 1'b1,
              '{KIND_END, 8'h00, 6'd0, 8'h00, 7'd2, 1'b0}}
        };

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        stall_pct     = 73;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CFG)
            begin
                wait_drain();
                cfg_write(dir_rows[i].reg_sel, dir_rows[i].val);
            end
            else
                send_byte(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
        end

        // Two settings per idle mix: sender-light, receiver-light, then none
        for (setting = 0; setting < NUM_SETTINGS; setting++)
        begin
            case (setting / 2)
                0:       begin send_idle_pct = 13; stall_pct = 73; end
                1:       begin send_idle_pct = 73; stall_pct = 13; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            case (setting)
                0: next_cfg = '{1'b1, 8'h00, 8'hFF, 8'hFF};
                1: next_cfg = '{1'b0, 8'hFF, 8'h00, 8'h00};
                2: next_cfg = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom)};
                3:
                begin
                    // both header bytes equal
                    next_cfg            = '{1'b0, 8'($urandom), 8'h00, 8'($urandom)};
                    next_cfg.head_second = next_cfg.head_first;
                end
                4: next_cfg = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom)};
                default: next_cfg = '{PROTOCOL_MODE_RST, HEAD_FIRST_RST,
                                      HEAD_SECOND_RST, VERSION_VALUE_RST};
            endcase
            wait_drain();
            cfg_write(REG_PROTOCOL_MODE, 8'(next_cfg.protocol_mode));
            cfg_write(REG_HEAD_FIRST, next_cfg.head_first);
            cfg_write(REG_HEAD_SECOND, next_cfg.head_second);
            cfg_write(REG_VERSION_VALUE, next_cfg.version_value);
            run_setting(BYTES_PER_SETTING);
        end

        wait_drain();

        $display("Summary: %0d bytes fed through %0d register settings and three idle mixes",
                 bytes_sent, NUM_SETTINGS);
        $display("Summary: %0d payload beats and %0d frame ends checked, %0d ends with good sum",
                 payload_seen, ends_seen, good_sums);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ufr_pkg.sv
hw/rtl/ufr_regs.sv
hw/rtl/ufr_parser.sv
hw/rtl/uart_frame_receiver.sv
tb/sv/uart_frame_receiver_tb.sv
